// File: rtl/rotation_matrix_to_quaternion_defines.svh
// Assertion macros for the rotation matrix to quaternion block.
// Used by the top level only; no other dependencies.
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RMQ_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("rmq: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RMQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("rmq: next-cycle check failed");

`endif

// File: rtl/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion block.
// No dependencies; used by rmq_search_stage and the top level.
package rmq_pkg;

  localparam int unsigned NUM_LANES = 4;
  localparam int unsigned OUT_FRAC  = 14;
  localparam int unsigned MAG_W     = 16;
  localparam int unsigned SQ_W      = 2 * MAG_W;
  localparam int unsigned VW        = OUT_FRAC + 1;
  localparam int unsigned NW        = SQ_W + 2;
  localparam int unsigned AW        = SQ_W + 2 * OUT_FRAC + 2;
  localparam int unsigned PW        = 70;
  localparam int unsigned OUT_W     = 16;

  // One quaternion component in the normalizing search.
  // p = (2v-1)^2 * n, q = (2v-1) * n, a = mag^2 << 30.
  typedef struct packed {
    logic signed [PW-1:0] p;
    logic signed [PW-1:0] q;
    logic [AW-1:0]        a;
    logic [VW-1:0]        v;
    logic                 neg;
  } rmq_lane_t;

  typedef struct packed {
    rmq_lane_t [NUM_LANES-1:0] lane;
    logic [NW-1:0]             n;
    logic                      degen;
  } rmq_item_t;

endpackage

// File: rtl/rmq_search_stage.sv
// One bit of the rounding search for |q| * 2^14 / sqrt(n), all four lanes.
// Depends on rmq_pkg for the item type and widths.
module rmq_search_stage #(
  parameter int unsigned Bit = 14
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  rmq_pkg::rmq_item_t item_i,
  output logic              valid_o,
  input  logic              ready_i,
  output rmq_pkg::rmq_item_t item_o
);

  logic                           valid_q;
  rmq_pkg::rmq_item_t             item_d;
  rmq_pkg::rmq_item_t             item_q;
  logic signed [rmq_pkg::PW-1:0]  nx;
  logic signed [rmq_pkg::PW-1:0]  pc   [rmq_pkg::NUM_LANES];
  logic [rmq_pkg::NUM_LANES-1:0]  ok;

  assign nx = signed'({{(rmq_pkg::PW - rmq_pkg::NW){1'b0}}, item_i.n});

  // Try v + 2^Bit: (2v-1 + 2^(Bit+1))^2 n expands to shifts and adds.
  for (genvar j = 0; j < rmq_pkg::NUM_LANES; j++) begin : g_lane
    assign pc[j] = item_i.lane[j].p + (item_i.lane[j].q <<< (Bit + 2))
                 + (nx <<< (2 * Bit + 2));
    assign ok[j] = pc[j] <= signed'({{(rmq_pkg::PW - rmq_pkg::AW){1'b0}},
                                     item_i.lane[j].a});
  end

  always_comb begin
    item_d = item_i;
    for (int j = 0; j < rmq_pkg::NUM_LANES; j++) begin
      if (ok[j]) begin
        item_d.lane[j].p = pc[j];
        item_d.lane[j].q = item_i.lane[j].q + (nx <<< (Bit + 1));
        item_d.lane[j].v = item_i.lane[j].v | (rmq_pkg::VW'(1) << Bit);
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: rtl/rotation_matrix_to_quaternion.sv
// Rotation matrix to unit quaternion: trace select, scaling, square root search.
// Depends on rmq_pkg, rmq_search_stage and rotation_matrix_to_quaternion_defines.svh.
//
// Input channel (in_valid_i / in_ready_o) carries one 3x3 matrix per beat,
// nine signed entries with FRAC_BITS fraction bits. Output channel
// (out_valid_o / out_ready_i) carries one unit quaternion per beat, Q1.14,
// plus a degenerate flag that is set, with all components zero, when the
// norm is zero.
//
// The block is a 20-stage pipeline: trace sums and branch select, magnitude
// scaling, squaring, norm sum, fifteen stages of a bit-per-stage rounding
// search (one result bit of |q| * 2^14 / sqrt(n) each), and the output
// register. One matrix is taken every cycle while the output is not stalled.
//
// Each stage holds its beat while the next stage cannot take it, so a stall on the
// output backs up stage by stage; empty stages still fill, and the input is
// refused only once every stage holds a beat. Reset empties the pipeline.
`include "rotation_matrix_to_quaternion_defines.svh"

module rotation_matrix_to_quaternion #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] m_c0_r0_i,
  input  logic signed [15:0] m_c0_r1_i,
  input  logic signed [15:0] m_c0_r2_i,
  input  logic signed [15:0] m_c1_r0_i,
  input  logic signed [15:0] m_c1_r1_i,
  input  logic signed [15:0] m_c1_r2_i,
  input  logic signed [15:0] m_c2_r0_i,
  input  logic signed [15:0] m_c2_r1_i,
  input  logic signed [15:0] m_c2_r2_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] quat_w_o,
  output logic signed [15:0] quat_x_o,
  output logic signed [15:0] quat_y_o,
  output logic signed [15:0] quat_z_o,
  output logic               degenerate_o
);

  localparam int unsigned TW     = ((FRAC_BITS > 16) ? FRAC_BITS : 16) + 3;
  localparam int unsigned LW     = $clog2(TW + 1);
  localparam int unsigned NL     = rmq_pkg::NUM_LANES;
  localparam int unsigned MW     = rmq_pkg::MAG_W;
  localparam int unsigned NSTEPS = rmq_pkg::VW;

  // ---------------- stage 1: traces and branch select ----------------
  logic signed [TW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22, one_c;
  logic signed [TW-1:0] t0, t1, t2, t3, tb;
  logic [1:0]           best;
  logic signed [TW-1:0] s1_q_d [NL];
  logic signed [TW-1:0] s1_q_q [NL];
  logic                 s1_valid_q, s1_rdy;

  assign m00   = TW'(m_c0_r0_i);
  assign m01   = TW'(m_c0_r1_i);
  assign m02   = TW'(m_c0_r2_i);
  assign m10   = TW'(m_c1_r0_i);
  assign m11   = TW'(m_c1_r1_i);
  assign m12   = TW'(m_c1_r2_i);
  assign m20   = TW'(m_c2_r0_i);
  assign m21   = TW'(m_c2_r1_i);
  assign m22   = TW'(m_c2_r2_i);
  assign one_c = signed'({{(TW-1){1'b0}}, 1'b1} << FRAC_BITS);

  assign t0 = one_c + m00 + m11 + m22;
  assign t1 = one_c + m00 - m11 - m22;
  assign t2 = one_c - m00 + m11 - m22;
  assign t3 = one_c - m00 - m11 + m22;

  // Ties keep the lower index.
  always_comb begin
    best = 2'd0;
    tb   = t0;
    if (t1 > tb) begin
      best = 2'd1;
      tb   = t1;
    end
    if (t2 > tb) begin
      best = 2'd2;
      tb   = t2;
    end
    if (t3 > tb) begin
      best = 2'd3;
    end
  end

  always_comb begin
    case (best)
      2'd0: begin
        s1_q_d[0] = t0;
        s1_q_d[1] = m12 - m21;
        s1_q_d[2] = m20 - m02;
        s1_q_d[3] = m01 - m10;
      end
      2'd1: begin
        s1_q_d[0] = m12 - m21;
        s1_q_d[1] = t1;
        s1_q_d[2] = m01 + m10;
        s1_q_d[3] = m20 + m02;
      end
      2'd2: begin
        s1_q_d[0] = m20 - m02;
        s1_q_d[1] = m01 + m10;
        s1_q_d[2] = t2;
        s1_q_d[3] = m12 + m21;
      end
      default: begin
        s1_q_d[0] = m01 - m10;
        s1_q_d[1] = m20 + m02;
        s1_q_d[2] = m12 + m21;
        s1_q_d[3] = t3;
      end
    endcase
  end

  // ---------------- stage 2: magnitudes, common scaling ----------------
  logic [TW-1:0]   mag    [NL];
  logic [TW-1:0]   mag_or;
  logic [LW-1:0]   len;
  logic [LW-1:0]   sh;
  logic [MW-1:0]   s2_a_q [NL];
  logic [NL-1:0]   s2_neg_q;
  logic            s2_valid_q, s2_rdy;

  always_comb begin
    mag_or = '0;
    for (int j = 0; j < NL; j++) begin
      mag[j] = s1_q_q[j][TW-1] ? TW'(-s1_q_q[j]) : TW'(s1_q_q[j]);
      mag_or = mag_or | mag[j];
    end
  end

  // Bit length of the OR equals that of the largest magnitude.
  always_comb begin
    len = '0;
    for (int i = 0; i < TW; i++) begin
      if (mag_or[i]) len = LW'(i + 1);
    end
  end

  assign sh = (len > LW'(MW)) ? (len - LW'(MW)) : '0;

  // ---------------- stage 3: squares ----------------
  logic [rmq_pkg::SQ_W-1:0] s3_sq_q [NL];
  logic [NL-1:0]            s3_neg_q;
  logic                     s3_valid_q, s3_rdy;

  // ---------------- stage 4: norm and search seed ----------------
  logic [rmq_pkg::NW-1:0] nsum;
  rmq_pkg::rmq_item_t     s4_d, s4_q;
  logic                   s4_valid_q, s4_rdy;

  always_comb begin
    nsum = '0;
    for (int j = 0; j < NL; j++) begin
      nsum = nsum + rmq_pkg::NW'(s3_sq_q[j]);
    end
  end

  always_comb begin
    s4_d.n     = nsum;
    s4_d.degen = (nsum == '0);
    for (int j = 0; j < NL; j++) begin
      // v = 0 gives 2v-1 = -1.
      s4_d.lane[j].p   = signed'(rmq_pkg::PW'(nsum));
      s4_d.lane[j].q   = -signed'(rmq_pkg::PW'(nsum));
      s4_d.lane[j].a   = rmq_pkg::AW'(s3_sq_q[j]) << (2 * rmq_pkg::OUT_FRAC + 2);
      s4_d.lane[j].v   = '0;
      s4_d.lane[j].neg = s3_neg_q[j];
    end
  end

  // ---------------- search stages ----------------
  logic               st_valid [NSTEPS+1];
  logic               st_ready [NSTEPS+1];
  rmq_pkg::rmq_item_t st_item  [NSTEPS+1];

  assign st_valid[0] = s4_valid_q;
  assign st_item[0]  = s4_q;
  assign s4_rdy      = !s4_valid_q || st_ready[0];

  for (genvar s = 0; s < NSTEPS; s++) begin : g_search
    rmq_search_stage #(
      .Bit(NSTEPS - 1 - s)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(st_valid[s]),
      .ready_o(st_ready[s]),
      .item_i (st_item[s]),
      .valid_o(st_valid[s+1]),
      .ready_i(st_ready[s+1]),
      .item_o (st_item[s+1])
    );
  end

  // ---------------- output register ----------------
  logic                           out_valid_q, out_rdy;
  logic signed [rmq_pkg::OUT_W-1:0] comp_d [NL];
  logic signed [rmq_pkg::OUT_W-1:0] comp_q [NL];
  logic                           degen_q;

  always_comb begin
    for (int j = 0; j < NL; j++) begin
      if (st_item[NSTEPS].degen) begin
        comp_d[j] = '0;
      end else if (st_item[NSTEPS].lane[j].neg) begin
        comp_d[j] = -signed'(rmq_pkg::OUT_W'(st_item[NSTEPS].lane[j].v));
      end else begin
        comp_d[j] = signed'(rmq_pkg::OUT_W'(st_item[NSTEPS].lane[j].v));
      end
    end
  end

  assign out_rdy          = !out_valid_q || out_ready_i;
  assign st_ready[NSTEPS] = out_rdy;

  // ---------------- handshake chain for the front stages ----------------
  assign s3_rdy     = !s3_valid_q || s4_rdy;
  assign s2_rdy     = !s2_valid_q || s3_rdy;
  assign s1_rdy     = !s1_valid_q || s2_rdy;
  assign in_ready_o = s1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_rdy)  s1_valid_q  <= in_valid_i;
      if (s2_rdy)  s2_valid_q  <= s1_valid_q;
      if (s3_rdy)  s3_valid_q  <= s2_valid_q;
      if (s4_rdy)  s4_valid_q  <= s3_valid_q;
      if (out_rdy) out_valid_q <= st_valid[NSTEPS];
    end
  end

  // Payload advances only with a beat; bubbles leave it untouched.
  always_ff @(posedge clk_i) begin
    if (s1_rdy && in_valid_i) begin
      for (int j = 0; j < NL; j++) s1_q_q[j] <= s1_q_d[j];
    end
    if (s2_rdy && s1_valid_q) begin
      for (int j = 0; j < NL; j++) begin
        s2_a_q[j]   <= MW'(mag[j] >> sh);
        s2_neg_q[j] <= s1_q_q[j][TW-1];
      end
    end
    if (s3_rdy && s2_valid_q) begin
      for (int j = 0; j < NL; j++) begin
        s3_sq_q[j] <= rmq_pkg::SQ_W'(s2_a_q[j]) * rmq_pkg::SQ_W'(s2_a_q[j]);
      end
      s3_neg_q <= s2_neg_q;
    end
    if (s4_rdy && s3_valid_q) begin
      s4_q <= s4_d;
    end
    if (out_rdy && st_valid[NSTEPS]) begin
      for (int j = 0; j < NL; j++) comp_q[j] <= comp_d[j];
      degen_q <= st_item[NSTEPS].degen;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign quat_w_o     = comp_q[0];
  assign quat_x_o     = comp_q[1];
  assign quat_y_o     = comp_q[2];
  assign quat_z_o     = comp_q[3];
  assign degenerate_o = degen_q;

  // ---------------- checks ----------------
  `RMQ_ASSERT_NOW(a_degen_zero, clk_i, rst_ni, out_valid_o && degenerate_o,
    quat_w_o == 16'sd0 && quat_x_o == 16'sd0 && quat_y_o == 16'sd0 && quat_z_o == 16'sd0)
  `RMQ_ASSERT_NOW(a_unit_range, clk_i, rst_ni, out_valid_o,
    quat_w_o >= -16'sd16384 && quat_w_o <= 16'sd16384 &&
    quat_x_o >= -16'sd16384 && quat_x_o <= 16'sd16384 &&
    quat_y_o >= -16'sd16384 && quat_y_o <= 16'sd16384 &&
    quat_z_o >= -16'sd16384 && quat_z_o <= 16'sd16384)
  `RMQ_ASSERT_NOW(a_nonzero, clk_i, rst_ni, out_valid_o && !degenerate_o,
    quat_w_o != 16'sd0 || quat_x_o != 16'sd0 || quat_y_o != 16'sd0 || quat_z_o != 16'sd0)
  `RMQ_ASSERT_NEXT(a_seed_flows, clk_i, rst_ni, s4_valid_q && st_ready[0],
    st_valid[1])

endmodule

// File: verif/tb.sv
// Testbench for rotation_matrix_to_quaternion: random and directed matrices,
// expected quaternions from an in-bench exact-integer predictor. Needs only the RTL.
`timescale 1ns / 100ps

module tb;

  typedef struct {
    logic signed [15:0] e [9];
  } matrix_t;

  typedef struct {
    logic signed [15:0] w, x, y, z;
    logic               degen;
  } quat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] m_i [9] = '{default: '0};
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [15:0] quat_w_o, quat_x_o, quat_y_o, quat_z_o;
  logic degenerate_o;

  matrix_t pending_q [$];
  quat_t   quat_expected_q [$];
  int      mismatch_cnt = 0;
  bit      stim_done = 1'b0;
  bit      calm = 1'b0;
  bit      in_taken = 1'b0;
  int      in_gap = 0, out_gap = 0;

  always #2 clk_i = ~clk_i;

  rotation_matrix_to_quaternion u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .m_c0_r0_i(m_i[0]), .m_c0_r1_i(m_i[1]), .m_c0_r2_i(m_i[2]),
    .m_c1_r0_i(m_i[3]), .m_c1_r1_i(m_i[4]), .m_c1_r2_i(m_i[5]),
    .m_c2_r0_i(m_i[6]), .m_c2_r1_i(m_i[7]), .m_c2_r2_i(m_i[8]),
    .out_valid_o, .out_ready_i,
    .quat_w_o, .quat_x_o, .quat_y_o, .quat_z_o, .degenerate_o
  );

  // floor(a * 2^14 / sqrt(n) + 1/2) by binary search on the odd numerator
  function automatic longint unsigned unit_component(longint unsigned a, longint unsigned n);
    longint unsigned rhs, lo, hi, mid, d;
    rhs = (a * a) << 30;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      d = 2 * mid - 1;
      if (d * d * n <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic quat_t predict_quat(matrix_t mt);
    longint m [3][3];
    longint t [4], q [4];
    longint unsigned mag [4], maxmag, n, v;
    int best, sh;
    quat_t r;
    for (int c = 0; c < 3; c++)
      for (int k = 0; k < 3; k++) m[c][k] = longint'(mt.e[c*3+k]);
    t[0] = 16384 + m[0][0] + m[1][1] + m[2][2];
    t[1] = 16384 + m[0][0] - m[1][1] - m[2][2];
    t[2] = 16384 - m[0][0] + m[1][1] - m[2][2];
    t[3] = 16384 - m[0][0] - m[1][1] + m[2][2];
    best = 0;
    for (int k = 1; k < 4; k++) if (t[k] > t[best]) best = k;
    case (best)
      0: begin
        q[0] = t[0];               q[1] = m[1][2] - m[2][1];
        q[2] = m[2][0] - m[0][2];  q[3] = m[0][1] - m[1][0];
      end
      1: begin
        q[0] = m[1][2] - m[2][1];  q[1] = t[1];
        q[2] = m[0][1] + m[1][0];  q[3] = m[2][0] + m[0][2];
      end
      2: begin
        q[0] = m[2][0] - m[0][2];  q[1] = m[0][1] + m[1][0];
        q[2] = t[2];               q[3] = m[1][2] + m[2][1];
      end
      default: begin
        q[0] = m[0][1] - m[1][0];  q[1] = m[2][0] + m[0][2];
        q[2] = m[1][2] + m[2][1];  q[3] = t[3];
      end
    endcase
    maxmag = 0;
    for (int k = 0; k < 4; k++) begin
      mag[k] = (q[k] < 0) ? longint'(-q[k]) : longint'(q[k]);
      if (mag[k] > maxmag) maxmag = mag[k];
    end
    sh = 0;
    while ((maxmag >> sh) > 65535) sh++;
    n = 0;
    for (int k = 0; k < 4; k++) begin
      mag[k] = mag[k] >> sh;
      n += mag[k] * mag[k];
    end
    r.w = '0; r.x = '0; r.y = '0; r.z = '0; r.degen = 1'b1;
    if (n != 0) begin
      r.degen = 1'b0;
      for (int k = 0; k < 4; k++) begin
        v = unit_component(mag[k], n);
        if (q[k] < 0) v = -v;
        case (k)
          0: r.w = v[15:0];
          1: r.x = v[15:0];
          2: r.y = v[15:0];
          default: r.z = v[15:0];
        endcase
      end
    end
    return r;
  endfunction

  // record whether the input beat on the bus was taken at this edge
  always @(posedge clk_i) begin
    in_taken <= in_valid_i && in_ready_o;
  end

  // driver: advance on accepted beat, hold payload otherwise
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_taken) begin
        // hold
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_q.size() > 0 && !(!calm && $urandom_range(0, 19) == 0)) begin
        in_valid_i <= 1'b1;
        for (int i = 0; i < 9; i++) m_i[i] <= pending_q[0].e[i];
        quat_expected_q.push_back(predict_quat(pending_q[0]));
        void'(pending_q.pop_front());
      end else begin
        in_valid_i <= 1'b0;
        if (!calm && pending_q.size() > 0) in_gap <= $urandom_range(1, 17) - 1;
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 19) == 0) begin
        out_gap <= $urandom_range(1, 17) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // monitor: compare every accepted output beat with the oldest expectation
  always @(posedge clk_i) begin
    quat_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (quat_expected_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected output beat");
      end else begin
        e = quat_expected_q.pop_front();
        if (e.w !== quat_w_o || e.x !== quat_x_o || e.y !== quat_y_o
            || e.z !== quat_z_o || e.degen !== degenerate_o) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp %0d %0d %0d %0d %b got %0d %0d %0d %0d %b",
                     e.w, e.x, e.y, e.z, e.degen,
                     quat_w_o, quat_x_o, quat_y_o, quat_z_o, degenerate_o);
        end
      end
    end
  end

  function automatic matrix_t rand_rotation();
    matrix_t r;
    int dom;
    // mostly near-rotation content with a random dominant trace branch
    for (int i = 0; i < 9; i++) r.e[i] = $urandom_range(0, 8191) - 4096;
    dom = $urandom_range(0, 3);
    r.e[0] = (dom == 0 || dom == 1) ? 16'sd16000 : -16'sd16000;
    r.e[4] = (dom == 0 || dom == 2) ? 16'sd16000 : -16'sd16000;
    r.e[8] = (dom == 0 || dom == 3) ? 16'sd16000 : -16'sd16000;
    for (int i = 0; i < 9; i += 4) r.e[i] += $urandom_range(0, 767) - 384;
    return r;
  endfunction

  task automatic add_fill(logic signed [15:0] v);
    matrix_t r;
    for (int i = 0; i < 9; i++) r.e[i] = v;
    pending_q.push_back(r);
  endtask

  task automatic add_diag(logic signed [15:0] a, logic signed [15:0] b,
                          logic signed [15:0] c);
    matrix_t r;
    for (int i = 0; i < 9; i++) r.e[i] = '0;
    r.e[0] = a; r.e[4] = b; r.e[8] = c;
    pending_q.push_back(r);
  endtask

  initial begin
    matrix_t r;
    // directed: identity, each branch, ties, extremes
    add_diag(16384, 16384, 16384);
    add_diag(16384, -16384, -16384);
    add_diag(-16384, 16384, -16384);
    add_diag(-16384, -16384, 16384);
    add_diag(0, 0, 0);
    add_diag(-16384, -16384, -16384);
    add_diag(16384, 16384, -16384);
    add_fill(16'sh7fff);
    add_fill(-16'sh8000);
    add_fill(0);
    add_fill(-1);
    add_diag(16'sh7fff, 16'sh7fff, 16'sh7fff);
    add_diag(-16'sh8000, -16'sh8000, -16'sh8000);
    add_diag(16'sh7fff, -16'sh8000, -16'sh8000);
    for (int i = 0; i < 9; i++) r.e[i] = (i % 2) ? 16'sh7fff : -16'sh8000;
    pending_q.push_back(r);
    for (int i = 0; i < 9; i++) r.e[i] = (i % 2) ? -16'sh8000 : 16'sh7fff;
    pending_q.push_back(r);
    for (int k = 0; k < 1300; k++) begin
      if ($urandom_range(0, 3) != 0) r = rand_rotation();
      else for (int i = 0; i < 9; i++) r.e[i] = $urandom;
      pending_q.push_back(r);
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    wait (pending_q.size() < 200);
    calm = 1'b1;
    wait (pending_q.size() == 0);
    @(posedge clk_i);
    while (in_valid_i && !in_ready_o) @(posedge clk_i);
    @(posedge clk_i);
    wait (quat_expected_q.size() == 0);
    repeat (40) @(posedge clk_i);
    if (mismatch_cnt == 0 && quat_expected_q.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #400000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
